// ===== src/bfwq_pkg.sv =====
// shared types and constants for the blocking fifo with waiter queue
// no dependencies; used by every module of the block except bfwq_fifo
package bfwq_pkg;

   localparam int DATA_DEPTH_DEF   = 16;
   localparam int WAITER_DEPTH_DEF = 16;
   localparam int DATA_WIDTH_DEF   = 32;

   localparam int MODE_W   = 2;
   localparam int ITEM_W   = 32;
   localparam int ID_W     = 8;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;
   localparam int SERVED_W = 32;

   typedef enum logic [MODE_W-1:0] {
      MODE_ENQ       = 2'd0,
      MODE_DEQ_BLOCK = 2'd1,
      MODE_DEQ_TRY   = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_STORED   = 3'd0,
      ST_HANDED   = 3'd1,
      ST_DEQUEUED = 3'd2,
      ST_WAITING  = 3'd3,
      ST_EMPTY    = 3'd4,
      ST_FULL     = 3'd5
   } status_type;

   // fifo occupancy flags seen by the decision logic
   typedef struct packed {
      logic data_empty;
      logic data_full;
      logic wait_empty;
      logic wait_full;
   } fifo_flags_type;

   // push/pop strobes produced by the decision logic
   typedef struct packed {
      logic data_push;
      logic data_pop;
      logic wait_push;
      logic wait_pop;
      logic served_inc;
   } op_ctrl_type;

endpackage

// ===== src/bfwq_fifo.sv =====
// circular fifo with a registered head word, used for data and waiter ids
// depends on nothing beyond its parameters
module bfwq_fifo #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH),
   localparam int FW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic             pop,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] head,
   output logic             empty,
   output logic             full,
   output logic [FW-1:0]    fill_next
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0]    fill_ff;
   logic [WIDTH-1:0] head_ff;

   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   assign wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
   assign rd_ptr_in = pop  ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
   assign fill_next = fill_ff + FW'(push) - FW'(pop);
   assign empty     = (fill_ff == '0);
   assign full      = (fill_ff == FW'(DEPTH));
   assign head      = head_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_next;
      end
   end

   // write port, and read of the next head with bypass of a same-slot write
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= wr_data;
      end
      if (push && (wr_ptr_ff == rd_ptr_in)) begin
         head_ff <= wr_data;
      end else begin
         head_ff <= mem[rd_ptr_in];
      end
   end

endmodule

// ===== src/bfwq_ctrl.sv =====
// decision logic: picks the fifo operations and status for one request
// depends on bfwq_pkg
module bfwq_ctrl (
   input  logic                     go,
   input  logic [bfwq_pkg::MODE_W-1:0] mode,
   input  bfwq_pkg::fifo_flags_type flags,
   output bfwq_pkg::op_ctrl_type    ops,
   output bfwq_pkg::status_type     status
);

   bfwq_pkg::op_ctrl_type raw;

   always_comb begin
      raw    = '0;
      status = bfwq_pkg::ST_EMPTY;
      unique case (bfwq_pkg::mode_type'(mode))
         bfwq_pkg::MODE_ENQ: begin
            if (!flags.wait_empty) begin
               raw.wait_pop   = 1'b1;
               raw.served_inc = 1'b1;
               status         = bfwq_pkg::ST_HANDED;
            end else if (flags.data_full) begin
               status = bfwq_pkg::ST_FULL;
            end else begin
               raw.data_push = 1'b1;
               status        = bfwq_pkg::ST_STORED;
            end
         end
         bfwq_pkg::MODE_DEQ_BLOCK: begin
            if (!flags.data_empty && flags.wait_empty) begin
               raw.data_pop   = 1'b1;
               raw.served_inc = 1'b1;
               status         = bfwq_pkg::ST_DEQUEUED;
            end else if (flags.wait_full) begin
               status = bfwq_pkg::ST_FULL;
            end else begin
               raw.wait_push = 1'b1;
               status        = bfwq_pkg::ST_WAITING;
            end
         end
         // try dequeue, and the unused mode code
         default: begin
            if (!flags.data_empty) begin
               raw.data_pop   = 1'b1;
               raw.served_inc = 1'b1;
               status         = bfwq_pkg::ST_DEQUEUED;
            end else begin
               status = bfwq_pkg::ST_EMPTY;
            end
         end
      endcase
   end

   assign ops = go ? raw : '0;

endmodule

// ===== src/blocking_fifo_with_waiter_queue_top.sv =====
// top level of the blocking fifo with waiter queue
// depends on bfwq_pkg, bfwq_fifo and bfwq_ctrl
//
// usage
//   request channel (req_*): mode 0 enqueues req_item_data, mode 1 is a
//   blocking dequeue, mode 2 (and 3) a try dequeue for req_requester_id
//   response channel (rsp_*): exactly one response per request, in order,
//   with status, delivered word, recipient id, both fill levels after the
//   request and the wrapping count of words delivered
//   a transfer happens on a rising edge with valid high and stall low
// pipeline and throughput
//   a request is captured in the input register; the decision and fifo
//   update are made from it, and the outcome is loaded into the result
//   register that presents the response; one request per cycle is
//   sustained while rsp_stall is low, set by the single decision pass
//   and the one read port of each fifo memory
// stall
//   while rsp_stall holds a response, the input register keeps its request
//   and req_stall rises once that register is occupied; nothing is lost
// reset
//   synchronous, active high: both fifos empty, served count zero, no
//   response pending; the fifo memories themselves are not cleared
module blocking_fifo_with_waiter_queue_top #(
   parameter int DATA_DEPTH   = bfwq_pkg::DATA_DEPTH_DEF,
   parameter int WAITER_DEPTH = bfwq_pkg::WAITER_DEPTH_DEF,
   parameter int DATA_WIDTH   = bfwq_pkg::DATA_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bfwq_pkg::MODE_W-1:0]       req_mode,
   input  logic [bfwq_pkg::ITEM_W-1:0]       req_item_data,
   input  logic [bfwq_pkg::ID_W-1:0]         req_requester_id,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bfwq_pkg::STATUS_W-1:0]     rsp_status,
   output logic [bfwq_pkg::ITEM_W-1:0]       rsp_out_data,
   output logic [bfwq_pkg::ID_W-1:0]         rsp_recipient_id,
   output logic [bfwq_pkg::COUNT_W-1:0]      rsp_item_count,
   output logic [bfwq_pkg::COUNT_W-1:0]      rsp_waiter_count,
   output logic [bfwq_pkg::SERVED_W-1:0]     rsp_served_count
);

   localparam int DFW = $clog2(DATA_DEPTH + 1);
   localparam int WFW = $clog2(WAITER_DEPTH + 1);

   // input register
   logic                          in_v_ff, in_v_in;
   logic [bfwq_pkg::MODE_W-1:0]   mode_ff;
   logic [bfwq_pkg::ITEM_W-1:0]   item_ff;
   logic [bfwq_pkg::ID_W-1:0]     id_ff;

   // result register
   logic                          out_v_ff, out_v_in;
   logic [bfwq_pkg::STATUS_W-1:0] status_ff;
   logic [bfwq_pkg::ITEM_W-1:0]   data_ff;
   logic [bfwq_pkg::ID_W-1:0]     recip_ff;
   logic [bfwq_pkg::COUNT_W-1:0]  icount_ff;
   logic [bfwq_pkg::COUNT_W-1:0]  wcount_ff;
   logic [bfwq_pkg::SERVED_W-1:0] served_ff, served_in;
   logic [bfwq_pkg::SERVED_W-1:0] served_rsp_ff;

   logic                          req_xfer;
   logic                          out_free;
   logic                          fire;

   bfwq_pkg::fifo_flags_type      flags;
   bfwq_pkg::op_ctrl_type         ops;
   bfwq_pkg::status_type          status;

   logic [DATA_WIDTH-1:0]         word;
   logic [DATA_WIDTH-1:0]         data_head;
   logic [bfwq_pkg::ID_W-1:0]     wait_head;
   logic [DFW-1:0]                data_fill_next;
   logic [WFW-1:0]                wait_fill_next;
   logic [bfwq_pkg::ITEM_W-1:0]   out_data;
   logic [bfwq_pkg::ID_W-1:0]     recip;

   // handshake: result register frees when empty or taken this cycle
   assign out_free  = !out_v_ff || !rsp_stall;
   assign fire      = in_v_ff && out_free;
   assign req_stall = in_v_ff && !out_free;
   assign req_xfer  = req_valid && !req_stall;

   assign in_v_in  = req_xfer ? 1'b1 : (fire ? 1'b0 : in_v_ff);
   assign out_v_in = out_free ? fire : out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff   <= 1'b0;
         out_v_ff  <= 1'b0;
         served_ff <= '0;
      end else begin
         in_v_ff   <= in_v_in;
         out_v_ff  <= out_v_in;
         served_ff <= served_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         mode_ff <= req_mode;
         item_ff <= req_item_data;
         id_ff   <= req_requester_id;
      end
   end

   // payload word held at the configured width
   assign word = DATA_WIDTH'(item_ff);

   bfwq_fifo #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DATA_DEPTH)
   ) u_data_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (ops.data_push),
      .pop       (ops.data_pop),
      .wr_data   (word),
      .head      (data_head),
      .empty     (flags.data_empty),
      .full      (flags.data_full),
      .fill_next (data_fill_next)
   );

   bfwq_fifo #(
      .WIDTH (bfwq_pkg::ID_W),
      .DEPTH (WAITER_DEPTH)
   ) u_wait_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (ops.wait_push),
      .pop       (ops.wait_pop),
      .wr_data   (id_ff),
      .head      (wait_head),
      .empty     (flags.wait_empty),
      .full      (flags.wait_full),
      .fill_next (wait_fill_next)
   );

   bfwq_ctrl u_ctrl (
      .go     (fire),
      .mode   (mode_ff),
      .flags  (flags),
      .ops    (ops),
      .status (status)
   );

   assign served_in = served_ff + bfwq_pkg::SERVED_W'(ops.served_inc);

   // delivered word and recipient follow the chosen outcome
   always_comb begin
      out_data = '0;
      recip    = '0;
      unique case (status)
         bfwq_pkg::ST_HANDED: begin
            out_data = bfwq_pkg::ITEM_W'(word);
            recip    = wait_head;
         end
         bfwq_pkg::ST_DEQUEUED: begin
            out_data = bfwq_pkg::ITEM_W'(data_head);
            recip    = id_ff;
         end
         bfwq_pkg::ST_WAITING: begin
            recip = id_ff;
         end
         default: begin
            out_data = '0;
            recip    = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         status_ff <= status;
         data_ff   <= out_data;
         recip_ff  <= recip;
         icount_ff <= bfwq_pkg::COUNT_W'(data_fill_next);
         wcount_ff <= bfwq_pkg::COUNT_W'(wait_fill_next);
      end
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_data     = data_ff;
   assign rsp_recipient_id = recip_ff;
   assign rsp_item_count   = icount_ff;
   assign rsp_waiter_count = wcount_ff;
   // served count registered together with the rest of the response
   always_ff @(posedge clock) begin
      if (fire) begin
         served_rsp_ff <= served_in;
      end
   end

   assign rsp_served_count = served_rsp_ff;

endmodule

// ===== src/bfwq_checker.sv =====
// port-level checks for the blocking fifo with waiter queue
// depends on bfwq_pkg; bound to blocking_fifo_with_waiter_queue_top
module bfwq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [bfwq_pkg::STATUS_W-1:0]     rsp_status,
   input logic [bfwq_pkg::ITEM_W-1:0]       rsp_out_data,
   input logic [bfwq_pkg::ID_W-1:0]         rsp_recipient_id,
   input logic [bfwq_pkg::COUNT_W-1:0]      rsp_item_count,
   input logic [bfwq_pkg::COUNT_W-1:0]      rsp_waiter_count,
   input logic [bfwq_pkg::SERVED_W-1:0]     rsp_served_count
);

   // a held response keeps its status, word, recipient id and served count
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_out_data) && $stable(rsp_recipient_id) &&
         $stable(rsp_served_count))
      else $error("response changed while stalled");

   // words are never stored while a requester waits
   a_not_both: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item_count == '0) || (rsp_waiter_count == '0))
      else $error("items and waiters present together");

   // only a delivery carries a word
   a_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != bfwq_pkg::ST_HANDED) &&
         (rsp_status != bfwq_pkg::ST_DEQUEUED) |-> rsp_out_data == '0)
      else $error("word reported without delivery");

   // empty report only when nothing is stored
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == bfwq_pkg::ST_EMPTY) |-> rsp_item_count == '0)
      else $error("empty reported with items stored");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending after reset");

endmodule

bind blocking_fifo_with_waiter_queue_top bfwq_checker u_bfwq_checker (.*);
